// ===== rtl/cst_pkg.sv =====
// Package for the call slot tag tracker: sizes, codes, shared types and the
// handle packing functions. Depends on nothing; every file but cst_ram uses it.

package cst_pkg;

    localparam int NUM_SLOTS = 64;
    localparam int ID_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
    localparam int GEN_W     = 28;

    // Fixed field widths of the channels.
    localparam int FUNC_W    = 3;
    localparam int SLOT_W    = 6;
    localparam int WORD_W    = 32;
    localparam int STATUS_W  = 5;

    typedef enum logic [FUNC_W-1:0] {
        FN_ACQUIRE = 3'd0,
        FN_RELEASE = 3'd1,
        FN_POST    = 3'd2,
        FN_GET     = 3'd3,
        FN_TIMEOUT = 3'd4
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACQUIRED      = 5'd0,
        ST_NO_FREE       = 5'd1,
        ST_RELEASED      = 5'd2,
        ST_RELEASED_DISC = 5'd3,
        ST_STORED        = 5'd4,
        ST_WOKE          = 5'd5,
        ST_DUPLICATE     = 5'd6,
        ST_LATE          = 5'd7,
        ST_STALE         = 5'd8,
        ST_BAD_FORMAT    = 5'd9,
        ST_OUT_OF_RANGE  = 5'd10,
        ST_PENDING       = 5'd11,
        ST_DELIVERED     = 5'd12,
        ST_DUP_GET       = 5'd13,
        ST_TIMED_OUT     = 5'd14,
        ST_TIMEOUT_IGN   = 5'd15,
        ST_INVALID       = 5'd16
    } t_status;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_STORED  = 2'd1,
        PH_WAITING = 2'd2,
        PH_DONE    = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_ADDR = 2'd1,
        S_POP  = 2'd2,
        S_EXEC = 2'd3
    } t_state;

    // Per-slot bookkeeping held in one memory word.
    typedef struct packed {
        logic             is_free;
        t_phase           phase;
        logic [GEN_W-1:0] gen;
    } t_slot_info;

    localparam int INFO_W = $bits(t_slot_info);

    typedef struct packed {
        logic cap_in;
        logic rd_stack;
        logic rd_slot;
        logic from_stack;
        logic commit;
    } t_ctl_cmd;

    typedef struct packed {
        logic is_acquire;
        logic stack_empty;
        logic out_free;
    } t_dp_stat;

    typedef struct packed {
        logic        fmt_ok;
        logic [19:0] id;
        logic [18:0] mask;
    } t_hdl_dec;

    function automatic logic [WORD_W-1:0] make_handle(input logic [19:0] id,
                                                      input logic [GEN_W-1:0] gen);
        logic [WORD_W-1:0] h;
        if (id < 20'h00400) begin
            h = 32'h2000_0000 | (32'(id) << 19) | 32'(gen[18:0]);
        end else if (id < 20'h10000) begin
            h = 32'h4000_0000 | (32'(id) << 14) | 32'(gen[13:0]);
        end else begin
            h = 32'h8000_0000 | (32'(id) << 11) | 32'(gen[10:0]);
        end
        return h;
    endfunction

    // The header bits are tested from the top down.
    function automatic t_hdl_dec decode_handle(input logic [WORD_W-1:0] h);
        t_hdl_dec d;
        d.fmt_ok = 1'b1;
        if (h[31]) begin
            d.id   = h[30:11];
            d.mask = 19'h007FF;
        end else if (h[30]) begin
            d.id   = {4'b0, h[29:14]};
            d.mask = 19'h03FFF;
        end else if (h[29]) begin
            d.id   = {10'b0, h[28:19]};
            d.mask = 19'h7FFFF;
        end else begin
            d.fmt_ok = 1'b0;
            d.id     = '0;
            d.mask   = '0;
        end
        return d;
    endfunction

endpackage

// ===== rtl/cst_req_if.sv =====
// Request channel of the call slot tag tracker: valid/ready and the item fields.
// Depends on cst_pkg for the field widths.

interface cst_req_if;
    logic                        valid;
    logic                        ready;
    logic [cst_pkg::FUNC_W-1:0]  func;
    logic [cst_pkg::SLOT_W-1:0]  slot;
    logic [cst_pkg::WORD_W-1:0]  handle;
    logic [cst_pkg::WORD_W-1:0]  payload;

    modport source (output valid, output func, output slot, output handle,
                    output payload, input ready);
    modport sink   (input valid, input func, input slot, input handle,
                    input payload, output ready);
endinterface

// ===== rtl/cst_rsp_if.sv =====
// Result channel of the call slot tag tracker: valid/ready and the result fields.
// Depends on cst_pkg for the field widths.

interface cst_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [cst_pkg::STATUS_W-1:0]  status;
    logic [cst_pkg::SLOT_W-1:0]    slot_out;
    logic [cst_pkg::WORD_W-1:0]    handle_out;
    logic [cst_pkg::WORD_W-1:0]    payload_out;

    modport source (output valid, output status, output slot_out, output handle_out,
                    output payload_out, input ready);
    modport sink   (input valid, input status, input slot_out, input handle_out,
                    input payload_out, output ready);
endinterface

// ===== rtl/cst_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// Stands alone; used for every memory of the tracker.

module cst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/cst_ctrl.sv =====
// Sequencer of the call slot tag tracker: walks each item through address,
// stack pop (an acquire with a non-empty stack only), slot lookup and commit. Depends on cst_pkg.

module cst_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cst_pkg::t_dp_stat i_stat,
    output cst_pkg::t_ctl_cmd o_cmd
);
    import cst_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                if (i_stat.is_acquire && !i_stat.stack_empty) begin
                    n_state = S_POP;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_POP: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.cap_in = i_in_valid;
            end
            S_ADDR: begin
                if (i_stat.is_acquire && !i_stat.stack_empty) begin
                    o_cmd.rd_stack = 1'b1;
                end else begin
                    o_cmd.rd_slot = 1'b1;
                end
            end
            S_POP: begin
                o_cmd.rd_slot    = 1'b1;
                o_cmd.from_stack = 1'b1;
            end
            S_EXEC: begin
                o_cmd.commit = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end
endmodule

// ===== rtl/cst_dpath.sv =====
// Datapath of the call slot tag tracker: item registers, slot and stack
// memories with their valid bits, the decision logic and the result register.
// Depends on cst_pkg and cst_ram.

module cst_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cst_pkg::t_ctl_cmd            i_cmd,
    output cst_pkg::t_dp_stat            o_stat,
    input  logic [cst_pkg::FUNC_W-1:0]   i_func,
    input  logic [cst_pkg::SLOT_W-1:0]   i_slot,
    input  logic [cst_pkg::WORD_W-1:0]   i_handle,
    input  logic [cst_pkg::WORD_W-1:0]   i_payload,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [cst_pkg::STATUS_W-1:0] o_status,
    output logic [cst_pkg::SLOT_W-1:0]   o_slot_out,
    output logic [cst_pkg::WORD_W-1:0]   o_handle_out,
    output logic [cst_pkg::WORD_W-1:0]   o_payload_out
);
    import cst_pkg::*;

    logic [FUNC_W-1:0]    r_func;
    logic [SLOT_W-1:0]    r_slot;
    logic [WORD_W-1:0]    r_handle;
    logic [WORD_W-1:0]    r_payload;
    logic [CNT_W-1:0]     r_free_cnt;
    logic [NUM_SLOTS-1:0] r_info_vld;
    logic [NUM_SLOTS-1:0] r_stk_vld;
    logic                 r_info_rvld;
    logic                 r_stk_rvld;
    logic [ID_W-1:0]      r_stk_raddr;
    logic [ID_W-1:0]      r_id;

    logic                 r_out_vld;
    t_status              r_out_status;
    logic [SLOT_W-1:0]    r_out_slot;
    logic [WORD_W-1:0]    r_out_handle;
    logic [WORD_W-1:0]    r_out_payload;

    t_hdl_dec             dec;
    logic [ID_W-1:0]      stk_raddr;
    logic [ID_W-1:0]      stk_rdata;
    logic [ID_W-1:0]      stk_word;
    logic [ID_W-1:0]      slot_raddr;
    logic [INFO_W-1:0]    info_rdata;
    logic [WORD_W-1:0]    pay_rdata;
    t_slot_info           info_rd;
    t_slot_info           n_info;
    logic                 slot_ok;
    logic                 post_in_range;
    logic                 gen_match;
    logic                 info_we;
    logic                 pay_we;
    logic                 stk_we;
    logic                 cnt_inc;
    logic                 cnt_dec;
    t_status              st;
    logic [SLOT_W-1:0]    sl_out;
    logic [WORD_W-1:0]    h_out;
    logic [WORD_W-1:0]    p_out;

    assign dec        = decode_handle(r_handle);
    assign stk_raddr  = ID_W'(r_free_cnt - CNT_W'(1));
    // An entry never pushed still holds its own index.
    assign stk_word   = r_stk_rvld ? stk_rdata : r_stk_raddr;
    assign slot_raddr = i_cmd.from_stack ? stk_word
                      : ((r_func == FN_POST) ? ID_W'(dec.id) : ID_W'(r_slot));

    assign o_stat.is_acquire  = (r_func == FN_ACQUIRE);
    assign o_stat.stack_empty = (r_free_cnt == '0);
    assign o_stat.out_free    = !r_out_vld || i_out_ready;

    cst_ram #(.WIDTH(ID_W), .DEPTH(NUM_SLOTS)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (ID_W'(r_free_cnt)),
        .i_wdata (r_id),
        .i_re    (i_cmd.rd_stack),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    cst_ram #(.WIDTH(INFO_W), .DEPTH(NUM_SLOTS)) u_info_ram (
        .i_clk   (i_clk),
        .i_we    (info_we),
        .i_waddr (r_id),
        .i_wdata (n_info),
        .i_re    (i_cmd.rd_slot),
        .i_raddr (slot_raddr),
        .o_rdata (info_rdata)
    );

    cst_ram #(.WIDTH(WORD_W), .DEPTH(NUM_SLOTS)) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (pay_we),
        .i_waddr (r_id),
        .i_wdata (r_payload),
        .i_re    (i_cmd.rd_slot),
        .i_raddr (slot_raddr),
        .o_rdata (pay_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_func    <= i_func;
            r_slot    <= i_slot;
            r_handle  <= i_handle;
            r_payload <= i_payload;
        end
        if (i_cmd.rd_stack) begin
            r_stk_rvld  <= r_stk_vld[stk_raddr];
            r_stk_raddr <= stk_raddr;
        end
        if (i_cmd.rd_slot) begin
            r_info_rvld <= r_info_vld[slot_raddr];
            r_id        <= slot_raddr;
        end
    end

    // A slot entry never written reads as free, idle, generation one.
    always_comb begin
        if (r_info_rvld) begin
            info_rd = t_slot_info'(info_rdata);
        end else begin
            info_rd.is_free = 1'b1;
            info_rd.phase   = PH_IDLE;
            info_rd.gen     = GEN_W'(1);
        end
    end

    assign slot_ok       = (32'(r_slot) < 32'(NUM_SLOTS)) && !info_rd.is_free;
    assign post_in_range = 32'(dec.id) < 32'(NUM_SLOTS);
    assign gen_match     = (info_rd.gen[18:0] & dec.mask) == (r_handle[18:0] & dec.mask);

    always_comb begin
        n_info  = info_rd;
        info_we = 1'b0;
        pay_we  = 1'b0;
        stk_we  = 1'b0;
        cnt_inc = 1'b0;
        cnt_dec = 1'b0;
        st      = ST_INVALID;
        sl_out  = r_slot;
        h_out   = '0;
        p_out   = '0;
        case (r_func)
            FN_ACQUIRE: begin
                if (r_free_cnt == '0) begin
                    st     = ST_NO_FREE;
                    sl_out = '0;
                end else begin
                    st             = ST_ACQUIRED;
                    sl_out         = SLOT_W'(r_id);
                    h_out          = make_handle(20'(r_id), info_rd.gen);
                    n_info.is_free = 1'b0;
                    info_we        = 1'b1;
                    cnt_dec        = 1'b1;
                end
            end
            FN_RELEASE: begin
                if (slot_ok) begin
                    st             = (info_rd.phase == PH_STORED) ? ST_RELEASED_DISC
                                                                  : ST_RELEASED;
                    n_info.gen     = info_rd.gen + GEN_W'(1);
                    n_info.phase   = PH_IDLE;
                    n_info.is_free = 1'b1;
                    info_we        = 1'b1;
                    if (r_free_cnt < CNT_W'(NUM_SLOTS)) begin
                        stk_we  = 1'b1;
                        cnt_inc = 1'b1;
                    end
                end
            end
            FN_POST: begin
                sl_out = '0;
                if (!dec.fmt_ok) begin
                    st = ST_BAD_FORMAT;
                end else if (!post_in_range) begin
                    st = ST_OUT_OF_RANGE;
                end else begin
                    sl_out = SLOT_W'(r_id);
                    if (!gen_match) begin
                        st = ST_STALE;
                    end else begin
                        case (info_rd.phase)
                            PH_IDLE: begin
                                st           = ST_STORED;
                                n_info.phase = PH_STORED;
                                info_we      = 1'b1;
                                pay_we       = 1'b1;
                            end
                            PH_STORED: begin
                                st = ST_DUPLICATE;
                            end
                            PH_WAITING: begin
                                st           = ST_WOKE;
                                p_out        = r_payload;
                                n_info.phase = PH_DONE;
                                info_we      = 1'b1;
                            end
                            default: begin
                                st = ST_LATE;
                            end
                        endcase
                    end
                end
            end
            FN_GET: begin
                if (slot_ok) begin
                    case (info_rd.phase)
                        PH_IDLE: begin
                            st           = ST_PENDING;
                            n_info.phase = PH_WAITING;
                            info_we      = 1'b1;
                        end
                        PH_STORED: begin
                            st           = ST_DELIVERED;
                            p_out        = pay_rdata;
                            n_info.phase = PH_DONE;
                            info_we      = 1'b1;
                        end
                        PH_WAITING: begin
                            st = ST_PENDING;
                        end
                        default: begin
                            st = ST_DUP_GET;
                        end
                    endcase
                end
            end
            FN_TIMEOUT: begin
                if (slot_ok) begin
                    if (info_rd.phase == PH_WAITING) begin
                        st           = ST_TIMED_OUT;
                        n_info.phase = PH_IDLE;
                        info_we      = 1'b1;
                    end else begin
                        st = ST_TIMEOUT_IGN;
                    end
                end
            end
            default: begin
                st = ST_INVALID;
            end
        endcase
        info_we = info_we && i_cmd.commit;
        pay_we  = pay_we && i_cmd.commit;
        stk_we  = stk_we && i_cmd.commit;
        cnt_inc = cnt_inc && i_cmd.commit;
        cnt_dec = cnt_dec && i_cmd.commit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_cnt <= CNT_W'(NUM_SLOTS);
            r_info_vld <= '0;
            r_stk_vld  <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (cnt_inc) begin
                r_free_cnt <= r_free_cnt + CNT_W'(1);
            end else if (cnt_dec) begin
                r_free_cnt <= r_free_cnt - CNT_W'(1);
            end
            if (info_we) begin
                r_info_vld[r_id] <= 1'b1;
            end
            if (stk_we) begin
                r_stk_vld[ID_W'(r_free_cnt)] <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_status  <= st;
            r_out_slot    <= sl_out;
            r_out_handle  <= h_out;
            r_out_payload <= p_out;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_status      = r_out_status;
    assign o_slot_out    = r_out_slot;
    assign o_handle_out  = r_out_handle;
    assign o_payload_out = r_out_payload;
endmodule

// ===== rtl/call_slot_tag_tracker.sv =====
// Top level of the call slot tag tracker: sequencer plus datapath.
// Depends on cst_pkg, cst_req_if, cst_rsp_if, cst_ctrl and cst_dpath.

// Each item on the request channel is taken, one at a time, and answered by
// exactly one item on the result channel. An item passes through accept, slot
// lookup and commit; an acquire that pops the free stack adds a stack pop ahead
// of the lookup, since the popped slot id must come back from the stack memory before
// the slot entry can be read; every memory has a registered read port. The
// result register lets the next item be accepted while a result still waits,
// but the commit of that next item waits until the result is taken. No
// clearing pass is needed after reset: entries never written read as idle,
// free, generation one, and the free stack as entry i holding i.

module call_slot_tag_tracker (
    input  logic     i_clk,
    input  logic     i_rst_n,
    cst_req_if.sink   i_req,
    cst_rsp_if.source o_rsp
);
    import cst_pkg::*;

    t_ctl_cmd cmd;
    t_dp_stat stat;

    cst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cst_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_func        (i_req.func),
        .i_slot        (i_req.slot),
        .i_handle      (i_req.handle),
        .i_payload     (i_req.payload),
        .o_out_valid   (o_rsp.valid),
        .i_out_ready   (o_rsp.ready),
        .o_status      (o_rsp.status),
        .o_slot_out    (o_rsp.slot_out),
        .o_handle_out  (o_rsp.handle_out),
        .o_payload_out (o_rsp.payload_out)
    );
endmodule

// ===== rtl/cst_checker.sv =====
// Port-level checks for the call slot tag tracker, bound to the top level.
// Depends on cst_pkg for the status codes.

module cst_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [4:0]  i_status,
    input logic [5:0]  i_slot_out,
    input logic [31:0] i_handle_out,
    input logic [31:0] i_payload_out
);
    import cst_pkg::*;

    // A result waiting to be taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before it was taken");

    // Items are worked on one at a time, so the block is busy after an accept.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request accepted while an item is still in work");

    // Only an acquire carries a handle.
    a_handle_only_acq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_ACQUIRED) |-> i_handle_out == '0)
        else $error("handle on a result other than an acquire");

    // Only a delivery or a woken waiter carries a payload.
    a_payload_only_delivery: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_DELIVERED) && (i_status != ST_WOKE)
            |-> i_payload_out == '0)
        else $error("payload on a result that delivers none");

    // An acquired handle uses the short packing and carries the slot id.
    a_handle_packing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_ACQUIRED)
            |-> (i_handle_out[31:29] == 3'b001) && (i_handle_out[28:19] == {4'b0, i_slot_out}))
        else $error("acquired handle does not match its slot");
endmodule

bind call_slot_tag_tracker cst_checker u_cst_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_status      (o_rsp.status),
    .i_slot_out    (o_rsp.slot_out),
    .i_handle_out  (o_rsp.handle_out),
    .i_payload_out (o_rsp.payload_out)
);

// ===== tb/call_slot_tag_tracker_test.sv =====
// Self-checking testbench for the call slot tag tracker: directed and random request items
// against a slot-table predictor, with random idling on both channels.
// Depends on cst_pkg, cst_req_if, cst_rsp_if and call_slot_tag_tracker.
`timescale 1ns / 100ps

module call_slot_tag_tracker_test;
    import cst_pkg::*;

    // Function code that the block does not know.
    localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 3'd7;

    typedef enum int {HF_ID10, HF_ID16, HF_ID20} t_handle_fmt;
    typedef enum int {MIX_STEADY, MIX_DRAIN, MIX_REFILL} t_mix;

    typedef struct {
        t_status            status;
        logic [SLOT_W-1:0]  slot;
        logic [WORD_W-1:0]  handle;
        logic [WORD_W-1:0]  payload;
    } t_slot_answer;

    class slot_table_mirror;
        t_phase             phase_tab[NUM_SLOTS];
        logic [GEN_W-1:0]   gen_tab[NUM_SLOTS];
        logic [WORD_W-1:0]  pay_tab[NUM_SLOTS];
        bit                 free_tab[NUM_SLOTS];
        logic [ID_W-1:0]    stack_tab[NUM_SLOTS];
        int                 stack_depth;
        t_slot_answer       expected_answers[$];
        int                 failures;

        function new();
            for (int i = 0; i < NUM_SLOTS; i++) begin
                phase_tab[i] = PH_IDLE;
                gen_tab[i]   = GEN_W'(1);
                pay_tab[i]   = '0;
                free_tab[i]  = 1'b1;
                stack_tab[i] = ID_W'(i);
            end
            stack_depth = NUM_SLOTS;
            failures    = 0;
        endfunction

        function logic [WORD_W-1:0] pack_handle(logic [19:0] id, logic [GEN_W-1:0] g,
                                                t_handle_fmt fmt);
            case (fmt)
                HF_ID10: return {3'b001, id[9:0], g[18:0]};
                HF_ID16: return {2'b01, id[15:0], g[13:0]};
                default: return {1'b1, id[19:0], g[10:0]};
            endcase
        endfunction

        function void random_held_slot(output bit found, output logic [SLOT_W-1:0] s);
            logic [SLOT_W-1:0] held[$];
            for (int i = 0; i < NUM_SLOTS; i++)
                if (!free_tab[i]) held.push_back(SLOT_W'(i));
            found = held.size() > 0;
            s = found ? held[$urandom_range(0, held.size() - 1)] : '0;
        endfunction

        // Works out the result of one accepted request item and updates the table.
        function void apply_request(logic [FUNC_W-1:0] func, logic [SLOT_W-1:0] s,
                                    logic [WORD_W-1:0] h, logic [WORD_W-1:0] pay);
            t_slot_answer       a;
            logic [19:0]        id;
            logic [18:0]        gmask;
            logic [ID_W-1:0]    top;
            bit                 slot_ok;
            a = '{ST_INVALID, s, '0, '0};
            slot_ok = (s < NUM_SLOTS) && !free_tab[s];
            case (func)
                FN_ACQUIRE: begin
                    if (stack_depth == 0 || stack_depth > NUM_SLOTS) begin
                        a = '{ST_NO_FREE, '0, '0, '0};
                    end else begin
                        stack_depth--;
                        top = stack_tab[stack_depth];
                        free_tab[top] = 1'b0;
                        a = '{ST_ACQUIRED, SLOT_W'(top),
                              pack_handle(20'(top), gen_tab[top],
                                          (top < 'h400) ? HF_ID10 :
                                          (top < 'h10000) ? HF_ID16 : HF_ID20), '0};
                    end
                end
                FN_RELEASE: begin
                    if (slot_ok) begin
                        a.status = (phase_tab[s] == PH_STORED) ? ST_RELEASED_DISC
                                                               : ST_RELEASED;
                        gen_tab[s]   = gen_tab[s] + GEN_W'(1);
                        phase_tab[s] = PH_IDLE;
                        pay_tab[s]   = '0;
                        free_tab[s]  = 1'b1;
                        if (stack_depth < NUM_SLOTS) begin
                            stack_tab[stack_depth] = ID_W'(s);
                            stack_depth++;
                        end
                    end
                end
                FN_POST: begin
                    a.slot = '0;
                    if (h[31]) begin
                        id = h[30:11];
                        gmask = 19'h007FF;
                    end else if (h[30]) begin
                        id = {4'b0, h[29:14]};
                        gmask = 19'h03FFF;
                    end else if (h[29]) begin
                        id = {10'b0, h[28:19]};
                        gmask = 19'h7FFFF;
                    end else begin
                        id = '0;
                        gmask = '0;
                    end
                    if (gmask == '0) begin
                        a.status = ST_BAD_FORMAT;
                    end else if (id >= NUM_SLOTS) begin
                        a.status = ST_OUT_OF_RANGE;
                    end else begin
                        a.slot = SLOT_W'(id);
                        if ((gen_tab[id[ID_W-1:0]][18:0] & gmask) != (h[18:0] & gmask)) begin
                            a.status = ST_STALE;
                        end else begin
                            case (phase_tab[id[ID_W-1:0]])
                                PH_IDLE: begin
                                    pay_tab[id[ID_W-1:0]]   = pay;
                                    phase_tab[id[ID_W-1:0]] = PH_STORED;
                                    a.status = ST_STORED;
                                end
                                PH_STORED: a.status = ST_DUPLICATE;
                                PH_WAITING: begin
                                    pay_tab[id[ID_W-1:0]]   = '0;
                                    phase_tab[id[ID_W-1:0]] = PH_DONE;
                                    a.status  = ST_WOKE;
                                    a.payload = pay;
                                end
                                default: a.status = ST_LATE;
                            endcase
                        end
                    end
                end
                FN_GET: begin
                    if (slot_ok) begin
                        case (phase_tab[s])
                            PH_IDLE: begin
                                phase_tab[s] = PH_WAITING;
                                a.status = ST_PENDING;
                            end
                            PH_STORED: begin
                                a.status  = ST_DELIVERED;
                                a.payload = pay_tab[s];
                                pay_tab[s]   = '0;
                                phase_tab[s] = PH_DONE;
                            end
                            PH_WAITING: a.status = ST_PENDING;
                            default: a.status = ST_DUP_GET;
                        endcase
                    end
                end
                FN_TIMEOUT: begin
                    if (slot_ok) begin
                        if (phase_tab[s] == PH_WAITING) begin
                            phase_tab[s] = PH_IDLE;
                            a.status = ST_TIMED_OUT;
                        end else begin
                            a.status = ST_TIMEOUT_IGN;
                        end
                    end
                end
                default: ;
            endcase
            expected_answers.push_back(a);
        endfunction

        function void compare_field(string name, logic [WORD_W-1:0] want,
                                    logic [WORD_W-1:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
                failures++;
            end
        endfunction

        function void check_answer(logic [STATUS_W-1:0] st, logic [SLOT_W-1:0] sl,
                                   logic [WORD_W-1:0] h, logic [WORD_W-1:0] p);
            t_slot_answer want;
            if (expected_answers.size() == 0) begin
                $display("%0t: result with none outstanding, expected nothing, actual status %0d",
                         $time, st, " slot %0d handle 0x%08h payload 0x%08h", sl, h, p);
                failures++;
                return;
            end
            want = expected_answers.pop_front();
            compare_field("status", 32'(want.status), 32'(st));
            compare_field("slot_out", 32'(want.slot), 32'(sl));
            compare_field("handle_out", want.handle, h);
            compare_field("payload_out", want.payload, p);
        endfunction
    endclass

    localparam int TOTAL_ITEMS = 1650;
    localparam int DIRECTED_ITEMS = 26;
    localparam int CALM_ITEMS = 150;
    localparam int LONG_HOLD_AT = 300;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    bit   calm = 1'b0;
    bit   send_gaps_on = 1'b1;
    int   cycle_count = 0;

    slot_table_mirror mirror = new();

    cst_req_if req_ch ();
    cst_rsp_if rsp_ch ();

    call_slot_tag_tracker DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Offers one item, at times with a random gap in front of it, and waits for it to be taken.
    task automatic issue_request(logic [FUNC_W-1:0] func, logic [SLOT_W-1:0] s,
                                 logic [WORD_W-1:0] h, logic [WORD_W-1:0] pay);
        if (!calm && send_gaps_on && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        if ($urandom_range(0, 39) == 0) send_gaps_on = !send_gaps_on;
        req_ch.func    <= func;
        req_ch.slot    <= s;
        req_ch.handle  <= h;
        req_ch.payload <= pay;
        req_ch.valid   <= 1'b1;
        do @(posedge i_clk); while (!(req_ch.valid && req_ch.ready));
        mirror.apply_request(func, s, h, pay);
    endtask

    task automatic directed_checks();
        issue_request(FN_GET, 6'd5, '0, '0);
        issue_request(FN_TIMEOUT, 6'd63, '0, '0);
        issue_request(FN_UNUSED_HI, 6'd63, '1, '1);
        // Slot 63 sits on top of the free stack after reset.
        issue_request(FN_ACQUIRE, '0, '0, '0);
        issue_request(FN_POST, '0, mirror.pack_handle(20'd63, mirror.gen_tab[63], HF_ID10), '1);
        issue_request(FN_POST, '0, mirror.pack_handle(20'd63, mirror.gen_tab[63], HF_ID10), '0);
        issue_request(FN_GET, 6'd63, '0, '0);
        issue_request(FN_GET, 6'd63, '0, '0);
        issue_request(FN_POST, '0, mirror.pack_handle(20'd63, mirror.gen_tab[63], HF_ID16), '1);
        issue_request(FN_RELEASE, 6'd63, '0, '0);
        issue_request(FN_RELEASE, 6'd63, '0, '0);
        issue_request(FN_POST, '0,
                      mirror.pack_handle(20'd63, mirror.gen_tab[63] - GEN_W'(1), HF_ID20),
                      '1);
        issue_request(FN_POST, '0, '0, '1);
        issue_request(FN_POST, '0, '1, '1);
        issue_request(FN_POST, '0, mirror.pack_handle(20'd1023, '0, HF_ID10), '0);
        issue_request(FN_ACQUIRE, '0, '0, '0);
        issue_request(FN_GET, 6'd63, '0, '0);
        issue_request(FN_TIMEOUT, 6'd63, '0, '0);
        issue_request(FN_TIMEOUT, 6'd63, '0, '0);
        issue_request(FN_GET, 6'd63, '0, '0);
        issue_request(FN_POST, '0, mirror.pack_handle(20'd63, mirror.gen_tab[63], HF_ID20), '0);
        issue_request(FN_RELEASE, 6'd63, '0, '0);
        issue_request(FN_ACQUIRE, '0, '0, '0);
        issue_request(FN_POST, '0, mirror.pack_handle(20'd63, mirror.gen_tab[63], HF_ID10),
                      32'hA5A5_5A5A);
        issue_request(FN_RELEASE, 6'd63, '0, '0);
        // A response that reaches a free slot with a matching generation is still stored.
        issue_request(FN_POST, '0, mirror.pack_handle(20'd63, mirror.gen_tab[63], HF_ID16),
                      32'h0123_4567);
    endtask

    function automatic logic [FUNC_W-1:0] FN_FUNC_ANY();
        return FUNC_W'($urandom_range(FN_ACQUIRE, FN_UNUSED_HI));
    endfunction

    task automatic random_request(t_mix mix);
        int                 acquire_pct;
        int                 release_top;
        int                 pick;
        bit                 found;
        logic [SLOT_W-1:0]  held;
        logic [SLOT_W-1:0]  s;
        logic [FUNC_W-1:0]  func;
        logic [WORD_W-1:0]  h;
        logic [WORD_W-1:0]  pay;
        t_handle_fmt        fmt;
        h   = $urandom;
        pay = $urandom;
        s   = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
        fmt = t_handle_fmt'($urandom_range(HF_ID10, HF_ID20));
        acquire_pct = (mix == MIX_DRAIN) ? 55 : (mix == MIX_REFILL) ? 5 : 18;
        release_top = (mix == MIX_REFILL) ? 90 : 77;
        mirror.random_held_slot(found, held);
        pick = $urandom_range(0, 99);
        if (pick < acquire_pct || (!found && pick < 80)) begin
            func = FN_ACQUIRE;
        end else begin
            pick = found ? $urandom_range(0, 99) : 100;
            if (pick < 30) begin
                func = FN_POST;
                s = held;
                h = mirror.pack_handle(20'(held), mirror.gen_tab[held], fmt);
            end else if (pick < 52) begin
                func = FN_GET;
                s = held;
            end else if (pick < 62) begin
                func = FN_TIMEOUT;
                s = held;
            end else if (pick < release_top) begin
                func = FN_RELEASE;
                s = held;
            end else begin
                // Noise: any function code on any slot, and malformed or late responses.
                func = FN_FUNC_ANY();
                if (func == FN_POST) begin
                    case ($urandom_range(0, 4))
                        0: h = $urandom;
                        1: h = $urandom & 32'h1FFF_FFFF;
                        2: begin
                            case (fmt)
                                HF_ID10: h = mirror.pack_handle(
                                                 20'($urandom_range(NUM_SLOTS, 1023)),
                                                 GEN_W'($urandom), fmt);
                                HF_ID16: h = mirror.pack_handle(
                                                 20'($urandom_range(NUM_SLOTS, 65535)),
                                                 GEN_W'($urandom), fmt);
                                default: h = mirror.pack_handle(
                                                 20'($urandom_range(NUM_SLOTS, 20'hFFFFF)),
                                                 GEN_W'($urandom), fmt);
                            endcase
                        end
                        3: h = mirror.pack_handle(20'(s),
                                                  GEN_W'(mirror.gen_tab[s] +
                                                         $urandom_range(1, 7)), fmt);
                        default: h = mirror.pack_handle(20'(s), mirror.gen_tab[s], fmt);
                    endcase
                end
            end
        end
        issue_request(func, s, h, pay);
    endtask

    task automatic random_traffic();
        t_mix mix;
        int   mix_left;
        mix = MIX_STEADY;
        mix_left = 0;
        for (int n = 0; n < TOTAL_ITEMS - DIRECTED_ITEMS; n++) begin
            if (mix_left == 0) begin
                mix = t_mix'($urandom_range(MIX_STEADY, MIX_REFILL));
                mix_left = $urandom_range(60, 150);
            end
            mix_left--;
            if (n == TOTAL_ITEMS - DIRECTED_ITEMS - CALM_ITEMS) calm <= 1'b1;
            random_request(mix);
        end
    endtask

    // Result side: random stall bursts, one long hold-off, and steady acceptance at the end.
    initial begin
        int  answers_taken;
        int  stall_left;
        bit  stall_window;
        bit  long_hold_done;
        answers_taken = 0;
        stall_left = 0;
        stall_window = 1'b1;
        long_hold_done = 1'b0;
        rsp_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            @(posedge i_clk);
            if (rsp_ch.valid && rsp_ch.ready) begin
                mirror.check_answer(rsp_ch.status, rsp_ch.slot_out, rsp_ch.handle_out,
                                    rsp_ch.payload_out);
                answers_taken++;
            end
            if (!long_hold_done && answers_taken >= LONG_HOLD_AT) begin
                long_hold_done = 1'b1;
                stall_left = LONG_HOLD_CYCLES;
            end else if (stall_left == 0 && !calm && stall_window &&
                         $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 13);
            end
            if ($urandom_range(0, 59) == 0) stall_window = !stall_window;
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("call_slot_tag_tracker regression: fail");
        $finish;
    end

    initial begin
        req_ch.valid   <= 1'b0;
        req_ch.func    <= '0;
        req_ch.slot    <= '0;
        req_ch.handle  <= '0;
        req_ch.payload <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_checks();
        random_traffic();
        req_ch.valid <= 1'b0;
        while (mirror.expected_answers.size() != 0) @(posedge i_clk);
        // Let any stray result show up before the verdict.
        repeat (8) @(posedge i_clk);
        if (mirror.failures == 0 && mirror.expected_answers.size() == 0) begin
            $display("call_slot_tag_tracker regression: pass");
        end else begin
            $display("call_slot_tag_tracker regression: fail");
        end
        $finish;
    end

endmodule
